// ===== src/mpa_pkg.sv =====
`default_nettype none

package mpa_pkg;

	// Default sizing of the block.
	localparam int DEF_MAX_WIDTH   = 256;
	localparam int DEF_MAX_POOL    = 8;
	localparam int DEF_SAMPLE_BITS = 16;

	// Register field widths and reset values.
	localparam int IMAGE_WIDTH_BITS = 9;
	localparam int POOL_SIZE_BITS   = 4;
	localparam logic [IMAGE_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 9'd256;
	localparam logic [POOL_SIZE_BITS-1:0]   POOL_SIZE_RESET   = 4'd2;

	// Configuration port.
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_POOL_SIZE   = 1'b1;

	// Output field widths.
	localparam int OFFSET_OUT_BITS = 3;
	localparam int INDEX_OUT_BITS  = 8;

	// Where the current sample lies relative to its pooling window.
	typedef struct packed {
		logic active;     // window lies wholly inside the map
		logic first;      // top-left sample of the window
		logic last_win;   // bottom-right sample of the window
		logic last_map;   // window is the final one of the map
	} pos_flags_t;

endpackage

`default_nettype wire

// ===== src/max_pool_2d_argmax.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    sample_value
// output    out        out_valid / out_ready  pooled_value, winner_row, winner_col,
//                                             out_col, out_row, last_in_map
// config    in         APB write / read       image_width (0x0), pool_size (0x4)
//
// One sample is taken every cycle unless the output stalls; a window's last sample
// passes the first stage, beside the registered store read, to the result register.
// Reset clears the position counters and both pipeline stages; the store
// holds no reset state since each window's first sample writes its entry.
// A stalled output holds its result; one more sample is still taken into the
// first stage, after which the input stalls until the result is taken.

module max_pool_2d_argmax import mpa_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_POOL    = DEF_MAX_POOL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ADDR_BITS-1:0]          paddr,
	input  wire logic [DATA_BITS-1:0]          pwdata,
	output logic [DATA_BITS-1:0]               prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      pooled_value,
	output logic [OFFSET_OUT_BITS-1:0]         winner_row,
	output logic [OFFSET_OUT_BITS-1:0]         winner_col,
	output logic [INDEX_OUT_BITS-1:0]          out_col,
	output logic [INDEX_OUT_BITS-1:0]          out_row,
	output logic                               last_in_map
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int OW  = MAX_POOL > 1 ? $clog2(MAX_POOL) : 1;
	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int PEW = $clog2(MAX_POOL + 1);

	// Configuration registers.
	logic [IMAGE_WIDTH_BITS-1:0] image_width_q;
	logic [POOL_SIZE_BITS-1:0]   pool_size_q;
	logic                        cfg_wr;
	logic [WEW-1:0]              width_eff;
	logic [PEW-1:0]              pool_eff;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RESET;
			pool_size_q   <= POOL_SIZE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IMAGE_WIDTH: image_width_q <= pwdata[IMAGE_WIDTH_BITS-1:0];
				REG_POOL_SIZE:   pool_size_q   <= pwdata[POOL_SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH: prdata = DATA_BITS'(image_width_q);
			REG_POOL_SIZE:   prdata = DATA_BITS'(pool_size_q);
			default:         prdata = '0;
		endcase
	end

	// Zero is taken as one; values above the build limit saturate.
	always_comb begin
		if (image_width_q == '0) begin
			width_eff = WEW'(1);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			width_eff = WEW'(MAX_WIDTH);
		end else begin
			width_eff = WEW'(image_width_q);
		end
		if (pool_size_q == '0) begin
			pool_eff = PEW'(1);
		end else if (int'(pool_size_q) > MAX_POOL) begin
			pool_eff = PEW'(MAX_POOL);
		end else begin
			pool_eff = PEW'(pool_size_q);
		end
	end

	// Handshake and stage control.
	logic       in_xfer;
	logic       s1_valid;
	logic       fire;

	assign fire     = s1_valid && (!out_valid || out_ready);
	assign in_ready = !s1_valid || fire;
	assign in_xfer  = in_valid && in_ready;

	// Position of the incoming sample.
	logic [CW-1:0] win_col, win_row;
	logic [OW-1:0] off_col, off_row;
	pos_flags_t    flags;

	mpa_position #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_POOL (MAX_POOL)
	) u_position (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (in_xfer),
		.restart  (cfg_wr),
		.width_eff(width_eff),
		.pool_eff (pool_eff),
		.win_col  (win_col),
		.win_row  (win_row),
		.off_col  (off_col),
		.off_row  (off_row),
		.flags    (flags)
	);

	// First stage: the sample and its position, alongside the store read.
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	pos_flags_t                    flags_s1;
	logic [CW-1:0]                 win_col_s1, win_row_s1;
	logic [OW-1:0]                 off_col_s1, off_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1  <= sample_value;
			flags_s1   <= flags;
			win_col_s1 <= win_col;
			win_row_s1 <= win_row;
			off_col_s1 <= off_col;
			off_row_s1 <= off_row;
		end
	end

	// Running maximum update; a later sample wins only if strictly greater.
	logic [SAMPLE_BITS-1:0] old_value;
	logic [OW-1:0]          old_row, old_col;
	logic                   take_new;
	logic [SAMPLE_BITS-1:0] new_value;
	logic [OW-1:0]          new_row, new_col;
	logic                   wr_en;

	assign take_new  = flags_s1.first || (sample_s1 > $signed(old_value));
	assign new_value = take_new ? sample_s1 : old_value;
	assign new_row   = flags_s1.first ? '0 : (take_new ? off_row_s1 : old_row);
	assign new_col   = flags_s1.first ? '0 : (take_new ? off_col_s1 : old_col);
	assign wr_en     = fire && flags_s1.active;

	mpa_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_POOL   (MAX_POOL),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_xfer),
		.rd_addr   (win_col),
		.wr_en     (wr_en),
		.wr_addr   (win_col_s1),
		.wr_value  (new_value),
		.wr_row    (new_row),
		.wr_col    (new_col),
		.best_value(old_value),
		.best_row  (old_row),
		.best_col  (old_col)
	);

	// Result register: loaded at the bottom-right sample of a live window.
	logic load_out;

	assign load_out = fire && flags_s1.active && flags_s1.last_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pooled_value <= new_value;
			winner_row   <= OFFSET_OUT_BITS'(new_row);
			winner_col   <= OFFSET_OUT_BITS'(new_col);
			out_col      <= INDEX_OUT_BITS'(win_col_s1);
			out_row      <= INDEX_OUT_BITS'(win_row_s1);
			last_in_map  <= flags_s1.last_map;
		end
	end

	// Checks on the stage control.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid && !out_ready |-> !in_ready)
		else $error("input taken while both stages are held");

	a_transfer_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> s1_valid)
		else $error("accepted sample missing from first stage");

	a_result_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire))
		else $error("result appeared without a first-stage transfer");

	a_last_is_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_in_map |-> out_row == out_col)
		else $error("final result of a map is not the corner window");

endmodule

`default_nettype wire

// ===== src/mpa_position.sv =====
`default_nettype none

module mpa_position import mpa_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_POOL  = DEF_MAX_POOL
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  advance,
	input  wire logic                                  restart,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        width_eff,
	input  wire logic [$clog2(MAX_POOL+1)-1:0]         pool_eff,
	output logic [$clog2(MAX_WIDTH)-1:0]               win_col,
	output logic [$clog2(MAX_WIDTH)-1:0]               win_row,
	output logic [(MAX_POOL > 1 ? $clog2(MAX_POOL) : 1)-1:0] off_col,
	output logic [(MAX_POOL > 1 ? $clog2(MAX_POOL) : 1)-1:0] off_row,
	output pos_flags_t                                 flags
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int OW  = MAX_POOL > 1 ? $clog2(MAX_POOL) : 1;
	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int PEW = $clog2(MAX_POOL + 1);
	localparam int XW  = $clog2(MAX_WIDTH + 2 * MAX_POOL + 1);

	logic [CW-1:0] in_col_q, in_row_q;
	logic [CW-1:0] win_col_q, win_row_q;
	logic [OW-1:0] off_col_q, off_row_q;

	logic [WEW-1:0] width_m1;
	logic [PEW-1:0] pool_m1;
	logic [XW-1:0]  width_x, pool_x;
	logic [XW-1:0]  base_col, base_row;
	logic           col_end, row_end, wcol_end, wrow_end;

	assign width_m1 = width_eff - WEW'(1);
	assign pool_m1  = pool_eff - PEW'(1);
	assign width_x  = XW'(width_eff);
	assign pool_x   = XW'(pool_eff);

	// First sample column and row of the current window.
	assign base_col = XW'(in_col_q) - XW'(off_col_q);
	assign base_row = XW'(in_row_q) - XW'(off_row_q);

	assign col_end  = in_col_q >= CW'(width_m1);
	assign row_end  = in_row_q >= CW'(width_m1);
	assign wcol_end = off_col_q >= OW'(pool_m1);
	assign wrow_end = off_row_q >= OW'(pool_m1);

	// A window counts only when it fits in the map; it is the last one when
	// a further window along that axis would not fit.
	always_comb begin
		flags.active   = (base_col + pool_x <= width_x) && (base_row + pool_x <= width_x);
		flags.first    = (off_col_q == '0) && (off_row_q == '0);
		flags.last_win = (off_col_q == OW'(pool_m1)) && (off_row_q == OW'(pool_m1));
		flags.last_map = (base_col + (pool_x << 1) > width_x)
			&& (base_row + (pool_x << 1) > width_x);
	end

	assign win_col = win_col_q;
	assign win_row = win_row_q;
	assign off_col = off_col_q;
	assign off_row = off_row_q;

	// Raster position counters, advanced once per accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			win_col_q <= '0;
			win_row_q <= '0;
			off_col_q <= '0;
			off_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			win_col_q <= '0;
			win_row_q <= '0;
			off_col_q <= '0;
			off_row_q <= '0;
		end else if (advance) begin
			if (col_end) begin
				in_col_q  <= '0;
				off_col_q <= '0;
				win_col_q <= '0;
				if (row_end) begin
					in_row_q  <= '0;
					off_row_q <= '0;
					win_row_q <= '0;
				end else begin
					in_row_q <= in_row_q + CW'(1);
					if (wrow_end) begin
						off_row_q <= '0;
						win_row_q <= win_row_q + CW'(1);
					end else begin
						off_row_q <= off_row_q + OW'(1);
					end
				end
			end else begin
				in_col_q <= in_col_q + CW'(1);
				if (wcol_end) begin
					off_col_q <= '0;
					win_col_q <= win_col_q + CW'(1);
				end else begin
					off_col_q <= off_col_q + OW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/mpa_store.sv =====
`default_nettype none

module mpa_store import mpa_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_POOL    = DEF_MAX_POOL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  rd_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
	input  wire logic                                  wr_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]          wr_addr,
	input  wire logic [SAMPLE_BITS-1:0]                wr_value,
	input  wire logic [(MAX_POOL > 1 ? $clog2(MAX_POOL) : 1)-1:0] wr_row,
	input  wire logic [(MAX_POOL > 1 ? $clog2(MAX_POOL) : 1)-1:0] wr_col,
	output logic [SAMPLE_BITS-1:0]                     best_value,
	output logic [(MAX_POOL > 1 ? $clog2(MAX_POOL) : 1)-1:0] best_row,
	output logic [(MAX_POOL > 1 ? $clog2(MAX_POOL) : 1)-1:0] best_col
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int OW = MAX_POOL > 1 ? $clog2(MAX_POOL) : 1;
	localparam int EW = SAMPLE_BITS + 2 * OW;

	// One entry per window column: running maximum and its offset.
	logic [EW-1:0] mem [MAX_WIDTH];
	logic [EW-1:0] rd_data_q;
	logic [EW-1:0] byp_data_q;
	logic          byp_q;
	logic [EW-1:0] wr_data;
	logic [EW-1:0] sel_data;

	assign wr_data = {wr_value, wr_row, wr_col};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; a write to the same entry in the same cycle is
	// forwarded so that back-to-back samples of one window see their update.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign sel_data   = byp_q ? byp_data_q : rd_data_q;
	assign best_value = sel_data[EW-1 -: SAMPLE_BITS];
	assign best_row   = sel_data[2*OW-1 -: OW];
	assign best_col   = sel_data[OW-1:0];

endmodule

`default_nettype wire
